// File: rtl/core/max_heap_extract_top_assert.svh
// Assertion macros for the checker file of the heap block.
`ifndef MAX_HEAP_EXTRACT_TOP_ASSERT_SVH
`define MAX_HEAP_EXTRACT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define MHE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define MHE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mhe_pkg.sv
package mhe_pkg;

  // Width of the step counter of the control program.
  localparam int STEP_W = 4;

  // Fixed field widths of the stream words.
  localparam int IN_VALUE_W  = 32;
  localparam int OUT_VALUE_W = 32;
  localparam int OUT_COUNT_W = 7;
  localparam int STATUS_W    = 2;

  typedef logic [STATUS_W-1:0] mhe_status_t;
  localparam mhe_status_t ST_OK    = 2'd0;
  localparam mhe_status_t ST_EMPTY = 2'd1;
  localparam mhe_status_t ST_FULL  = 2'd2;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef logic [STEP_W-1:0] mhe_step_t;
  localparam mhe_step_t STEP_WAIT     = 4'd0;
  localparam mhe_step_t STEP_DISPATCH = 4'd1;
  localparam mhe_step_t STEP_CHECK    = 4'd2;
  localparam mhe_step_t STEP_ROOT     = 4'd3;
  localparam mhe_step_t STEP_LAST     = 4'd4;
  localparam mhe_step_t STEP_LEVEL    = 4'd5;
  localparam mhe_step_t STEP_RIGHT    = 4'd6;
  localparam mhe_step_t STEP_SETTLE   = 4'd7;
  localparam mhe_step_t STEP_PLACE    = 4'd8;
  localparam mhe_step_t STEP_LOAD     = 4'd9;
  localparam mhe_step_t STEP_APPEND   = 4'd10;
  localparam mhe_step_t STEP_FULL     = 4'd11;
  localparam mhe_step_t STEP_EMPTY    = 4'd12;
  localparam mhe_step_t STEP_OUT      = 4'd15;

  typedef enum logic [3:0] {
    A_NOP,
    A_LATCH,
    A_RD_ROOT,
    A_TAKE_ROOT,
    A_TAKE_LAST,
    A_RD_LEFT,
    A_RD_RIGHT,
    A_SETTLE,
    A_WR_CUR,
    A_APPEND,
    A_SET_FULL,
    A_SET_EMPTY,
    A_EMIT
  } mhe_act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_IS_LOAD,
    C_EMPTY,
    C_LEFT_OUT,
    C_MOVED,
    C_FULL,
    C_OUT_BUSY
  } mhe_cond_t;

  typedef struct packed {
    mhe_act_t  act;
    mhe_cond_t cond;
    mhe_step_t target;
  } mhe_uword_t;

  // Status flags the datapath reports to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic is_load;
    logic empty;
    logic full;
    logic left_out;
    logic moved;
    logic out_busy;
  } mhe_flags_t;

  // Control program. A step whose condition holds jumps to its target,
  // otherwise it falls through to the next step; the last step wraps to zero.
  function automatic mhe_uword_t ucode(input mhe_step_t step);
    mhe_uword_t w;
    w = '{act: A_NOP, cond: C_ALWAYS, target: STEP_WAIT};
    unique case (step)
      STEP_WAIT:     w = '{act: A_LATCH,     cond: C_NO_INPUT, target: STEP_WAIT};
      STEP_DISPATCH: w = '{act: A_NOP,       cond: C_IS_LOAD,  target: STEP_LOAD};
      STEP_CHECK:    w = '{act: A_RD_ROOT,   cond: C_EMPTY,    target: STEP_EMPTY};
      STEP_ROOT:     w = '{act: A_TAKE_ROOT, cond: C_NEVER,    target: STEP_WAIT};
      STEP_LAST:     w = '{act: A_TAKE_LAST, cond: C_NEVER,    target: STEP_WAIT};
      STEP_LEVEL:    w = '{act: A_RD_LEFT,   cond: C_LEFT_OUT, target: STEP_PLACE};
      STEP_RIGHT:    w = '{act: A_RD_RIGHT,  cond: C_NEVER,    target: STEP_WAIT};
      STEP_SETTLE:   w = '{act: A_SETTLE,    cond: C_MOVED,    target: STEP_LEVEL};
      STEP_PLACE:    w = '{act: A_WR_CUR,    cond: C_ALWAYS,   target: STEP_OUT};
      STEP_LOAD:     w = '{act: A_NOP,       cond: C_FULL,     target: STEP_FULL};
      STEP_APPEND:   w = '{act: A_APPEND,    cond: C_ALWAYS,   target: STEP_OUT};
      STEP_FULL:     w = '{act: A_SET_FULL,  cond: C_ALWAYS,   target: STEP_OUT};
      STEP_EMPTY:    w = '{act: A_SET_EMPTY, cond: C_ALWAYS,   target: STEP_OUT};
      STEP_OUT:      w = '{act: A_EMIT,      cond: C_OUT_BUSY, target: STEP_OUT};
      default:       w = '{act: A_NOP,       cond: C_ALWAYS,   target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/mhe_useq.sv
module mhe_useq (
  input  logic               clk,
  input  logic               rst,
  input  mhe_pkg::mhe_flags_t flags,
  output mhe_pkg::mhe_act_t  act
);

  mhe_pkg::mhe_step_t  upc;
  mhe_pkg::mhe_step_t  upc_next;
  mhe_pkg::mhe_uword_t uw;
  logic                take;

  assign uw  = mhe_pkg::ucode(upc);
  assign act = uw.act;

  always_comb begin
    unique case (uw.cond)
      mhe_pkg::C_NEVER:    take = 1'b0;
      mhe_pkg::C_ALWAYS:   take = 1'b1;
      mhe_pkg::C_NO_INPUT: take = !flags.in_valid;
      mhe_pkg::C_IS_LOAD:  take = flags.is_load;
      mhe_pkg::C_EMPTY:    take = flags.empty;
      mhe_pkg::C_LEFT_OUT: take = flags.left_out;
      mhe_pkg::C_MOVED:    take = flags.moved;
      mhe_pkg::C_FULL:     take = flags.full;
      mhe_pkg::C_OUT_BUSY: take = flags.out_busy;
      default:             take = 1'b1;
    endcase
  end

  always_comb begin
    upc_next = take ? uw.target : upc + mhe_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= mhe_pkg::STEP_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// File: rtl/core/mhe_datapath.sv
module mhe_datapath #(
  parameter int HEAP_DEPTH  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mhe_pkg::mhe_act_t                  act,
  output mhe_pkg::mhe_flags_t                flags,
  input  logic                               in_valid,
  input  logic                               in_opcode,
  input  logic [mhe_pkg::IN_VALUE_W-1:0]     in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mhe_pkg::OUT_VALUE_W-1:0]    out_max_value,
  output logic [mhe_pkg::OUT_COUNT_W-1:0]    out_count_after,
  output mhe_pkg::mhe_status_t               out_status
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int PW = AW + 2;

  logic [VALUE_WIDTH-1:0] mem [HEAP_DEPTH];
  logic [VALUE_WIDTH-1:0] rdata;
  logic [AW-1:0]          raddr;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [VALUE_WIDTH-1:0] wdata;

  logic                   op;
  logic [VALUE_WIDTH-1:0] val;
  logic [CW-1:0]          count;
  logic [AW-1:0]          pos;
  logic [VALUE_WIDTH-1:0] cur;
  logic [VALUE_WIDTH-1:0] best_val;
  logic [AW-1:0]          best_idx;
  logic [VALUE_WIDTH-1:0] result;
  mhe_pkg::mhe_status_t   status;

  logic [PW-1:0]          lc;
  logic [PW-1:0]          rc;
  logic [PW-1:0]          cnt_ext;
  logic [CW-1:0]          cnt_m1;
  logic                   l_wins;
  logic                   r_wins;
  logic [VALUE_WIDTH-1:0] fin_val;
  logic [AW-1:0]          fin_idx;
  logic [63:0]            in_wide;
  logic [63:0]            res_wide;
  logic [31:0]            cnt_wide;
  logic                   out_busy;

  assign lc       = {1'b0, pos, 1'b1};
  assign rc       = lc + PW'(1);
  assign cnt_ext  = PW'(count);
  assign cnt_m1   = count - CW'(1);
  assign in_wide  = 64'(in_value);
  assign res_wide = 64'(result);
  assign cnt_wide = 32'(count);
  assign out_busy = out_valid && !out_ready;

  // Left child is compared with the sifted value, right child with that winner.
  assign l_wins  = $signed(rdata) > $signed(cur);
  assign r_wins  = (rc < cnt_ext) && ($signed(rdata) > $signed(best_val));
  assign fin_val = r_wins ? rdata : best_val;
  assign fin_idx = r_wins ? rc[AW-1:0] : best_idx;

  always_comb begin
    flags.in_valid = in_valid;
    flags.is_load  = (op == mhe_pkg::OP_LOAD);
    flags.empty    = (count == '0);
    flags.full     = (count == CW'(HEAP_DEPTH));
    flags.left_out = (lc >= cnt_ext);
    flags.moved    = (fin_idx != pos);
    flags.out_busy = out_busy;
  end

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = pos;
    wdata = cur;
    unique case (act)
      mhe_pkg::A_TAKE_ROOT: raddr = cnt_m1[AW-1:0];
      mhe_pkg::A_RD_LEFT:   raddr = lc[AW-1:0];
      mhe_pkg::A_RD_RIGHT:  raddr = rc[AW-1:0];
      mhe_pkg::A_SETTLE: begin
        we    = 1'b1;
        wdata = fin_val;
      end
      mhe_pkg::A_WR_CUR: begin
        we = 1'b1;
      end
      mhe_pkg::A_APPEND: begin
        we    = 1'b1;
        waddr = count[AW-1:0];
        wdata = val;
      end
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (act)
        mhe_pkg::A_LATCH: begin
          if (in_valid) begin
            op     <= in_opcode;
            val    <= in_wide[VALUE_WIDTH-1:0];
            result <= '0;
            status <= mhe_pkg::ST_OK;
          end
        end
        mhe_pkg::A_TAKE_ROOT: begin
          result <= rdata;
          count  <= cnt_m1;
        end
        mhe_pkg::A_TAKE_LAST: begin
          cur <= rdata;
          pos <= '0;
        end
        mhe_pkg::A_RD_RIGHT: begin
          best_val <= l_wins ? rdata : cur;
          best_idx <= l_wins ? lc[AW-1:0] : pos;
        end
        mhe_pkg::A_SETTLE:    pos    <= fin_idx;
        mhe_pkg::A_APPEND:    count  <= count + CW'(1);
        mhe_pkg::A_SET_FULL:  status <= mhe_pkg::ST_FULL;
        mhe_pkg::A_SET_EMPTY: status <= mhe_pkg::ST_EMPTY;
        default: begin
        end
      endcase

      if (act == mhe_pkg::A_EMIT && !out_busy) begin
        out_valid       <= 1'b1;
        out_max_value   <= res_wide[mhe_pkg::OUT_VALUE_W-1:0];
        out_count_after <= cnt_wide[mhe_pkg::OUT_COUNT_W-1:0];
        out_status      <= status;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/max_heap_extract_top.sv
// A load goes from the dispatch step through the load step and an append or full step to the
// output step; an extract checks for an empty heap, reads and takes the root and the last
// entry, then sinks that entry one level at a time and writes it in place. Each level costs
// three control steps around the single-read-port heap memory. One item is in flight, and the
// next input word can be taken the cycle after the result is loaded into the output register.
// Reset (rst, synchronous) empties the heap and the output register; memory is not cleared.
module max_heap_extract_top #(
  parameter int HEAP_DEPTH  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [0:0]  s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] max_value, [38:32] count_after, [39] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  // The sequencer steps through the control program and hands one action
  // per cycle to the datapath, which answers with the flags it branches on.
  mhe_pkg::mhe_act_t                    act;
  mhe_pkg::mhe_flags_t                  flags;
  logic [mhe_pkg::OUT_VALUE_W-1:0]      max_value;
  logic [mhe_pkg::OUT_COUNT_W-1:0]      count_after;
  mhe_pkg::mhe_status_t                 status;

  mhe_useq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .act   (act)
  );

  mhe_datapath #(
    .HEAP_DEPTH  (HEAP_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .act             (act),
    .flags           (flags),
    .in_valid        (s_tvalid),
    .in_opcode       (s_tuser[0]),
    .in_value        (s_tdata),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_max_value   (max_value),
    .out_count_after (count_after),
    .out_status      (status)
  );

  // The input word is taken only in the wait step of the program, which is
  // also where a finished result may still sit in the output register.
  // Nothing is taken while reset is held.
  assign s_tready = !rst && (act == mhe_pkg::A_LATCH);

  assign m_tdata = {1'b0, count_after, max_value};
  assign m_tuser = status;

endmodule

// File: rtl/core/mhe_checker.sv
module mhe_checker #(
  parameter int HEAP_DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser
);

`include "max_heap_extract_top_assert.svh"

  logic [6:0] depth_code;
  assign depth_code = 7'(HEAP_DEPTH);

  `MHE_ASSERT_NOW(a_full_word, m_tvalid && m_tuser == mhe_pkg::ST_FULL, m_tdata[31:0] == 32'd0 && m_tdata[38:32] == depth_code, "full-heap word has wrong value or count")
  `MHE_ASSERT_NOW(a_empty_word, m_tvalid && m_tuser == mhe_pkg::ST_EMPTY, m_tdata[38:0] == 39'd0, "empty-heap word has nonzero value or count")
  `MHE_ASSERT_NOW(a_status_code, m_tvalid, m_tuser == mhe_pkg::ST_OK || m_tuser == mhe_pkg::ST_EMPTY || m_tuser == mhe_pkg::ST_FULL, "output status code is reserved")
  `MHE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output word changed")

endmodule

bind max_heap_extract_top mhe_checker #(
  .HEAP_DEPTH (HEAP_DEPTH)
) u_mhe_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int HEAP_N = 64;
  localparam int RANDOM_WORDS = 450;
  // Long receiver hold-off, in cycles, taken after these result counts.
  localparam int RX_HOLD_CYCLES = 250;
  localparam int RX_HOLD_AT_A = 100;
  localparam int RX_HOLD_AT_B = 300;
  // Settle time after the last result.
  localparam int TAIL_CYCLES = 40;
  localparam longint VAL_MIN = -64'sd2147483648;

  // Two copies of the heap: one walks ahead with the stimulus so that loads
  // can be kept in heap order, the other follows the accepted words.
  localparam int GEN_COPY = 0;
  localparam int CHK_COPY = 1;

  typedef struct packed {
    logic [31:0] max_value;
    logic [6:0]  count_after;
    mhe_pkg::mhe_status_t status;
  } heap_result_t;

  typedef struct packed {
    logic        op;
    logic [31:0] value;
    logic        wait_drain;  // hold this word back until all results are in
  } stim_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;     // [31:0] value
  logic [0:0]  s_tuser = mhe_pkg::OP_LOAD; // [0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;          // [31:0] max_value, [38:32] count_after, [39] zero
  logic [1:0]  m_tuser;          // [1:0] status

  logic signed [31:0] heap_mem [2][HEAP_N];
  int unsigned        heap_cnt [2];

  stim_word_t   stim_q[$];
  heap_result_t heap_expect_q[$];

  int planned = 0;
  int words_sent = 0;
  int words_recv = 0;
  int failures = 0;
  int n_load = 0, n_extract = 0, n_full = 0, n_empty = 0, peak_count = 0;

  max_heap_extract_top #(
    .HEAP_DEPTH (HEAP_N),
    .VALUE_WIDTH(32)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one word to a heap copy and returns the result word it causes.
  // Sift-down takes the left child only when strictly greater, and the right
  // child only when strictly greater than the winner so far.
  function automatic void heap_apply(input int k, input logic op, input logic [31:0] value,
                                     output heap_result_t res);
    int unsigned pos, best, lc, rc;
    logic signed [31:0] held;
    bit settled;
    res = '{max_value: '0, count_after: '0, status: mhe_pkg::ST_OK};
    if (op == mhe_pkg::OP_LOAD) begin
      if (heap_cnt[k] >= HEAP_N) begin
        res.status = mhe_pkg::ST_FULL;
      end else begin
        heap_mem[k][heap_cnt[k]] = value;
        heap_cnt[k]++;
      end
    end else if (heap_cnt[k] == 0) begin
      res.status = mhe_pkg::ST_EMPTY;
    end else begin
      res.max_value = heap_mem[k][0];
      heap_cnt[k]--;
      heap_mem[k][0] = heap_mem[k][heap_cnt[k]];
      pos = 0;
      settled = 1'b0;
      while (!settled) begin
        best = pos;
        lc = 2 * pos + 1;
        rc = 2 * pos + 2;
        if (lc < heap_cnt[k] && heap_mem[k][lc] > heap_mem[k][best]) best = lc;
        if (rc < heap_cnt[k] && heap_mem[k][rc] > heap_mem[k][best]) best = rc;
        if (best == pos) begin
          settled = 1'b1;
        end else begin
          held = heap_mem[k][best];
          heap_mem[k][best] = heap_mem[k][pos];
          heap_mem[k][pos] = held;
          pos = best;
        end
      end
    end
    res.count_after = 7'(heap_cnt[k]);
  endfunction

  // A value that keeps the heap in order when appended at the next slot:
  // ties with the parent, values just below it, or anything down to the minimum.
  function automatic logic [31:0] next_in_order();
    longint parent, pick;
    int r;
    r = $urandom_range(0, 99);
    if (heap_cnt[GEN_COPY] == 0) begin
      if (r < 15) return 32'h7FFF_FFFF;
      if (r < 25) return 32'h8000_0000;
      return $urandom();
    end
    parent = heap_mem[GEN_COPY][(heap_cnt[GEN_COPY] - 1) / 2];
    if (r < 20) pick = parent;
    else if (r < 50) pick = parent - $urandom_range(1, 64);
    else pick = parent - longint'($urandom() % (parent - VAL_MIN + 1));
    if (pick < VAL_MIN) pick = VAL_MIN;
    return pick[31:0];
  endfunction

  // Idle length between words: mostly none or short, a few long, and now and
  // then a calm stretch of back-to-back words.
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) calm = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_word(input logic op, input logic [31:0] value, input logic drain);
    heap_result_t ignored;
    stim_q.push_back('{op: op, value: value, wait_drain: drain});
    heap_apply(GEN_COPY, op, value, ignored);
    planned++;
  endtask

  // Loads in heap order up to full, then a few loads that must be refused.
  task automatic fill_heap(input logic drain);
    int extra;
    extra = $urandom_range(1, 3);
    add_word(mhe_pkg::OP_LOAD, next_in_order(), drain);
    while (heap_cnt[GEN_COPY] < HEAP_N) add_word(mhe_pkg::OP_LOAD, next_in_order(), 1'b0);
    repeat (extra) add_word(mhe_pkg::OP_LOAD, $urandom(), 1'b0);
  endtask

  // Extracts down to empty, then a few that must be refused.
  task automatic drain_heap(input logic drain);
    int extra;
    extra = $urandom_range(1, 2);
    add_word(mhe_pkg::OP_EXTRACT, $urandom(), drain);
    while (heap_cnt[GEN_COPY] > 0) add_word(mhe_pkg::OP_EXTRACT, $urandom(), 1'b0);
    repeat (extra) add_word(mhe_pkg::OP_EXTRACT, $urandom(), 1'b0);
  endtask

  // Driver: offers words from stim_q and predicts the result of each word
  // at the edge where it is taken.
  logic         tx_took;
  heap_result_t tx_pred;
  stim_word_t   tx_next;
  int           tx_gap = 0;
  int           tx_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      tx_took = s_tvalid && s_tready;
      if (tx_took) begin
        heap_apply(CHK_COPY, s_tuser[0], s_tdata, tx_pred);
        heap_expect_q.push_back(tx_pred);
        words_sent <= words_sent + 1;
        if (s_tuser[0] == mhe_pkg::OP_LOAD) n_load++;
        else n_extract++;
        if (tx_pred.status == mhe_pkg::ST_FULL) n_full++;
        if (tx_pred.status == mhe_pkg::ST_EMPTY) n_empty++;
        if (int'(tx_pred.count_after) > peak_count) peak_count = tx_pred.count_after;
      end
      if (s_tvalid && !s_tready) begin
        // Word still on offer; hold it.
      end else if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (stim_q.size() == 0 ||
                   (stim_q[0].wait_drain && (tx_took || words_sent != words_recv))) begin
        s_tvalid <= 1'b0;
      end else begin
        tx_next = stim_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= tx_next.value;
        s_tuser  <= tx_next.op;
        tx_gap = idle_len(tx_calm);
      end
    end
  end

  // Monitor: checks each result word against the oldest prediction and
  // throttles m_tready, with two long hold-offs to back the block up.
  heap_result_t rx_want;
  int           rx_gap = 0;
  int           rx_calm = 0;
  int           rx_hold = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        words_recv <= words_recv + 1;
        if (heap_expect_q.size() == 0) begin
          failures++;
          $display("%0t: result word with nothing expected: max_value %0d count %0d status %0d",
                   $time, $signed(m_tdata[31:0]), m_tdata[38:32], m_tuser);
        end else begin
          rx_want = heap_expect_q.pop_front();
          if (m_tdata[31:0] !== rx_want.max_value) begin
            failures++;
            $display("%0t: max_value expected %0d got %0d", $time,
                     $signed(rx_want.max_value), $signed(m_tdata[31:0]));
          end
          if (m_tdata[38:32] !== rx_want.count_after) begin
            failures++;
            $display("%0t: count_after expected %0d got %0d", $time,
                     rx_want.count_after, m_tdata[38:32]);
          end
          if (m_tuser !== rx_want.status) begin
            failures++;
            $display("%0t: status expected %0d got %0d", $time, rx_want.status, m_tuser);
          end
        end
        if (words_recv + 1 == RX_HOLD_AT_A || words_recv + 1 == RX_HOLD_AT_B)
          rx_hold = RX_HOLD_CYCLES;
        else
          rx_gap = idle_len(rx_calm);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int kind, len, bias;
    logic drain, op;
    heap_cnt = '{0, 0};
    for (int i = 0; i < HEAP_N; i++) begin
      heap_mem[GEN_COPY][i] = '0;
      heap_mem[CHK_COPY][i] = '0;
    end

    // Directed words: extract from an empty heap, extreme values with ties,
    // draining back past empty, then loads that break heap order.
    add_word(mhe_pkg::OP_EXTRACT, 32'h0000_0000, 1'b0);
    add_word(mhe_pkg::OP_LOAD, 32'h7FFF_FFFF, 1'b0);
    add_word(mhe_pkg::OP_LOAD, 32'h7FFF_FFFF, 1'b0);
    add_word(mhe_pkg::OP_LOAD, 32'h0000_0000, 1'b0);
    add_word(mhe_pkg::OP_LOAD, 32'h8000_0000, 1'b0);
    add_word(mhe_pkg::OP_LOAD, 32'hFFFF_FFFF, 1'b0);
    add_word(mhe_pkg::OP_LOAD, 32'h8000_0000, 1'b0);
    repeat (7) add_word(mhe_pkg::OP_EXTRACT, 32'hFFFF_FFFF, 1'b0);
    add_word(mhe_pkg::OP_LOAD, 32'd5, 1'b0);
    add_word(mhe_pkg::OP_LOAD, 32'd9, 1'b0);
    add_word(mhe_pkg::OP_LOAD, 32'd9, 1'b0);
    repeat (4) add_word(mhe_pkg::OP_EXTRACT, 32'h5555_AAAA, 1'b0);

    // Random part: fill to full first, after the directed results are in,
    // then a mix of fills, drains, balanced runs and unordered noise.
    fill_heap(1'b1);
    while (planned < RANDOM_WORDS) begin
      kind = $urandom_range(0, 9);
      drain = ($urandom_range(0, 3) == 0);
      if (kind < 2) begin
        fill_heap(drain);
      end else if (kind < 4) begin
        drain_heap(drain);
      end else if (kind < 9) begin
        len = $urandom_range(15, 40);
        bias = $urandom_range(25, 80);
        for (int i = 0; i < len; i++) begin
          op = ($urandom_range(0, 99) < bias) ? mhe_pkg::OP_LOAD : mhe_pkg::OP_EXTRACT;
          add_word(op, (op == mhe_pkg::OP_LOAD) ? next_in_order() : $urandom(),
                   drain && i == 0);
        end
      end else begin
        len = $urandom_range(4, 12);
        for (int i = 0; i < len; i++)
          add_word($urandom_range(0, 1) ? mhe_pkg::OP_EXTRACT : mhe_pkg::OP_LOAD, $urandom(),
                   drain && i == 0);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || s_tvalid || heap_expect_q.size() != 0 ||
           words_sent != words_recv)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d loads (%0d into a full heap) and %0d extracts (%0d from an empty heap).",
             n_load, n_full, n_extract, n_empty);
    $display("Heap filled to %0d entries; %0d result words checked.", peak_count, words_recv);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/mhe_pkg.sv
rtl/core/mhe_useq.sv
rtl/core/mhe_datapath.sv
rtl/core/max_heap_extract_top.sv
rtl/core/mhe_checker.sv
tb/sv/tb.sv
